// ===== rtl/core/slbm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slbm_pkg
// Shared types and constants for the serial loaded bank mapper.
// ----------------------------------------------------------------------------
package slbm_pkg;

  localparam int unsigned BANK_W  = 5;
  localparam int unsigned COUNT_W = 3;
  localparam int unsigned CHR_W   = 5;
  localparam int unsigned PRG_W   = 4;

  // Control register value after reset: PRG mode three, one-screen low.
  localparam logic [BANK_W-1:0] CTRL_RESET_VAL  = 5'd12;
  // Bits forced on by a reset write (PRG mode three).
  localparam logic [BANK_W-1:0] CTRL_MODE3_BITS = 5'b01100;
  // Count value at which the next write is the fifth one.
  localparam logic [COUNT_W-1:0] COUNT_LAST     = 3'd4;

  typedef enum logic [1:0] {
    REG_CONTROL = 2'd0,
    REG_CHR0    = 2'd1,
    REG_CHR1    = 2'd2,
    REG_PRG     = 2'd3
  } reg_sel_t;

  typedef enum logic [1:0] {
    PRG_MODE_32K_A = 2'd0,
    PRG_MODE_32K_B = 2'd1,
    PRG_MODE_FIX_LO = 2'd2,
    PRG_MODE_FIX_HI = 2'd3
  } prg_mode_t;

  typedef enum logic [1:0] {
    MIR_ONE_LO = 2'd0,
    MIR_ONE_HI = 2'd1,
    MIR_VERT   = 2'd2,
    MIR_HORZ   = 2'd3
  } mirror_t;

  typedef struct packed {
    logic cpu_read_n;
    logic rom_select_n;
    logic cpu_addr_13;
    logic cpu_addr_14;
    logic data_bit_zero;
    logic data_bit_seven;
    logic phi_two;
    logic ppu_addr_10;
    logic ppu_addr_11;
    logic ppu_addr_12;
  } in_item_t;

  typedef struct packed {
    logic [CHR_W-1:0] chr_bank_lines;
    logic [PRG_W-1:0] prg_bank_lines;
    logic             nametable_a10;
    logic             sram_enable;
    logic             prg_enable_n;
  } out_item_t;

  // Bank register file contents as seen by the output decode.
  typedef struct packed {
    logic [BANK_W-1:0] control;
    logic [BANK_W-1:0] chr0;
    logic [BANK_W-1:0] chr1;
    logic [BANK_W-1:0] prg;
  } bank_regs_t;

endpackage
`default_nettype wire

// ===== rtl/core/slbm_serial_load.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slbm_serial_load
// Serial shift register, write counter and the four bank registers.
// ----------------------------------------------------------------------------
module slbm_serial_load (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               item_fire,
  input  wire slbm_pkg::in_item_t item,
  output slbm_pkg::bank_regs_t    regs_nxt
);

  logic [slbm_pkg::BANK_W-1:0]  shift_r, shift_nxt;
  logic [slbm_pkg::COUNT_W-1:0] count_r, count_nxt;
  slbm_pkg::bank_regs_t         regs_r;
  logic [slbm_pkg::BANK_W-1:0]  shift_in;
  logic                         rom_wr;
  slbm_pkg::reg_sel_t           sel;

  assign rom_wr   = item_fire && !item.cpu_read_n && !item.rom_select_n;
  assign shift_in = {item.data_bit_zero, shift_r[slbm_pkg::BANK_W-1:1]};
  assign sel      = slbm_pkg::reg_sel_t'({item.cpu_addr_14, item.cpu_addr_13});

  always_comb begin
    shift_nxt = shift_r;
    count_nxt = count_r;
    regs_nxt  = regs_r;
    if (rom_wr) begin
      if (item.data_bit_seven) begin
        // abort the sequence, force PRG mode three
        shift_nxt        = '0;
        count_nxt        = '0;
        regs_nxt.control = regs_r.control | slbm_pkg::CTRL_MODE3_BITS;
      end else if (count_r >= slbm_pkg::COUNT_LAST) begin
        shift_nxt = '0;
        count_nxt = '0;
        case (sel)
          slbm_pkg::REG_CONTROL: regs_nxt.control = shift_in;
          slbm_pkg::REG_CHR0:    regs_nxt.chr0    = shift_in;
          slbm_pkg::REG_CHR1:    regs_nxt.chr1    = shift_in;
          slbm_pkg::REG_PRG:     regs_nxt.prg     = shift_in;
          default:               regs_nxt.prg     = shift_in;
        endcase
      end else begin
        shift_nxt = shift_in;
        count_nxt = count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r        <= '0;
      count_r        <= '0;
      regs_r.control <= slbm_pkg::CTRL_RESET_VAL;
      regs_r.chr0    <= '0;
      regs_r.chr1    <= '0;
      regs_r.prg     <= '0;
    end else begin
      shift_r <= shift_nxt;
      count_r <= count_nxt;
      regs_r  <= regs_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= slbm_pkg::COUNT_LAST)
    else $error("write count out of range");

  a_empty_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (shift_r == '0))
    else $error("shift register not clear at start of sequence");

  a_reset_write: assert property (@(posedge clk) disable iff (!rst_n)
    (rom_wr && item.data_bit_seven) |=>
      ((regs_r.control & slbm_pkg::CTRL_MODE3_BITS) == slbm_pkg::CTRL_MODE3_BITS)
      && (count_r == '0))
    else $error("reset write did not force PRG mode three");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/slbm_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slbm_decode
// Bank line, mirroring and chip enable decode from the bank registers.
// ----------------------------------------------------------------------------
module slbm_decode (
  input  wire slbm_pkg::in_item_t   item,
  input  wire slbm_pkg::bank_regs_t regs,
  output slbm_pkg::out_item_t       res
);

  slbm_pkg::prg_mode_t mode;
  slbm_pkg::mirror_t   mir;

  assign mode = slbm_pkg::prg_mode_t'(regs.control[3:2]);
  assign mir  = slbm_pkg::mirror_t'(regs.control[1:0]);

  always_comb begin
    if (!regs.control[4]) begin
      res.chr_bank_lines = {regs.chr0[slbm_pkg::BANK_W-1:1], item.ppu_addr_12};
    end else begin
      res.chr_bank_lines = item.ppu_addr_12 ? regs.chr1 : regs.chr0;
    end

    case (mode)
      slbm_pkg::PRG_MODE_32K_A,
      slbm_pkg::PRG_MODE_32K_B:
        res.prg_bank_lines = {regs.prg[slbm_pkg::PRG_W-1:1], item.cpu_addr_14};
      slbm_pkg::PRG_MODE_FIX_LO:
        res.prg_bank_lines = item.cpu_addr_14 ? regs.prg[slbm_pkg::PRG_W-1:0] : '0;
      slbm_pkg::PRG_MODE_FIX_HI:
        res.prg_bank_lines = item.cpu_addr_14 ? '1 : regs.prg[slbm_pkg::PRG_W-1:0];
      default:
        res.prg_bank_lines = regs.prg[slbm_pkg::PRG_W-1:0];
    endcase

    case (mir)
      slbm_pkg::MIR_ONE_LO: res.nametable_a10 = 1'b0;
      slbm_pkg::MIR_ONE_HI: res.nametable_a10 = 1'b1;
      slbm_pkg::MIR_VERT:   res.nametable_a10 = item.ppu_addr_10;
      slbm_pkg::MIR_HORZ:   res.nametable_a10 = item.ppu_addr_11;
      default:              res.nametable_a10 = item.ppu_addr_11;
    endcase

    res.sram_enable  = item.rom_select_n & item.cpu_addr_13 & item.cpu_addr_14
                       & item.phi_two;
    res.prg_enable_n = item.rom_select_n | ~item.cpu_read_n;
  end

endmodule
`default_nettype wire

// ===== rtl/core/serial_loaded_bank_mapper_top.sv =====
// Result: registered; the result of an item is in the output register the
//   cycle after it is accepted.
// Throughput: one item per cycle while out_ready is high; set by the single register update path.
// Reset: synchronous, active low; clears the shift register and count, loads
//   control with PRG mode three, clears the bank registers and empties the output register.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// serial_loaded_bank_mapper_top
// Serial loaded bank mapper: one bus cycle per item, one result per item.
// ----------------------------------------------------------------------------
module serial_loaded_bank_mapper_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire slbm_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output slbm_pkg::out_item_t      out_data
);

  logic                 out_valid_r, out_valid_nxt;
  slbm_pkg::out_item_t  out_data_r, out_data_nxt;
  slbm_pkg::bank_regs_t regs_nxt;
  slbm_pkg::out_item_t  res;
  logic                 in_fire;

  // Take a new item whenever the output register is empty or is being drained
  // this cycle; the output register parts the two sides.
  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Register file update; regs_nxt is the state after this item's write.
  slbm_serial_load u_load (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_fire (in_fire),
    .item      (in_data),
    .regs_nxt  (regs_nxt)
  );

  // Outputs follow the updated registers, so decode from the next state.
  slbm_decode u_decode (
    .item (in_data),
    .regs (regs_nxt),
    .res  (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (in_fire) begin
      // load the result of the accepted item
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (out_ready) begin
      // drop the delivered result
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload holds without reset
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== verif/serial_loaded_bank_mapper_top_tb.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// serial_loaded_bank_mapper_top_tb
// Self-checking bench for the serial loaded bank mapper. A queue of bus
// cycles feeds a valid/ready driver; a bank-decode predictor tracks the
// shift register and bank registers and checks every output item in order.
// ----------------------------------------------------------------------------
module serial_loaded_bank_mapper_top_tb;

  localparam int ITEM_TARGET   = 1200;
  localparam int IDLE_PCT      = 9;
  // Cycle window in which neither side idles.
  localparam int CALM_FIRST    = 300;
  localparam int CALM_LAST     = 700;
  localparam int DRAIN_CYCLES  = 4;
  localparam int MAX_PRINTED   = 50;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  slbm_pkg::in_item_t  in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  slbm_pkg::out_item_t out_data;

  serial_loaded_bank_mapper_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // 12 ns period.
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Bus cycles waiting to be driven, and decoded lines waiting to be seen.
  slbm_pkg::in_item_t  pending_cycles[$];
  slbm_pkg::out_item_t expected_lines[$];

  int n_queued    = 0;
  int n_offered   = 0;
  int n_accepted  = 0;
  int n_checked   = 0;
  int n_errors    = 0;
  int n_bus_resets = 0;
  int cycle_no    = 0;
  int loads_seen[4] = '{0, 0, 0, 0};

  // Predictor copy of the mapper state.
  logic [slbm_pkg::BANK_W-1:0]  shift_q;
  logic [slbm_pkg::COUNT_W-1:0] count_q;
  logic [slbm_pkg::BANK_W-1:0]  ctrl_q;
  logic [slbm_pkg::BANK_W-1:0]  chr0_q;
  logic [slbm_pkg::BANK_W-1:0]  chr1_q;
  logic [slbm_pkg::BANK_W-1:0]  prg_q;

  function automatic bit calm_window();
    return (cycle_no >= CALM_FIRST) && (cycle_no <= CALM_LAST);
  endfunction

  function automatic bit rand_bit();
    return 1'($urandom_range(1));
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (n_errors < MAX_PRINTED)
      $display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    n_errors++;
  endtask

  task automatic reset_mapper_model();
    shift_q = '0;
    count_q = '0;
    ctrl_q  = slbm_pkg::CTRL_RESET_VAL;
    chr0_q  = '0;
    chr1_q  = '0;
    prg_q   = '0;
  endtask

  // Apply one bus cycle to the model state, then decode the lines from the
  // updated registers.
  task automatic decode_bus_cycle(input slbm_pkg::in_item_t it,
                                  output slbm_pkg::out_item_t res);
    logic [slbm_pkg::BANK_W-1:0] shifted;
    slbm_pkg::reg_sel_t          target;
    if (!it.cpu_read_n && !it.rom_select_n) begin
      if (it.data_bit_seven) begin
        // Serial reset: drop the partial value, force PRG mode three.
        shift_q = '0;
        count_q = '0;
        ctrl_q  = ctrl_q | slbm_pkg::CTRL_MODE3_BITS;
        n_bus_resets++;
      end else begin
        shifted = {it.data_bit_zero, shift_q[slbm_pkg::BANK_W-1:1]};
        if (count_q >= slbm_pkg::COUNT_LAST) begin
          target = slbm_pkg::reg_sel_t'({it.cpu_addr_14, it.cpu_addr_13});
          case (target)
            slbm_pkg::REG_CONTROL: ctrl_q = shifted;
            slbm_pkg::REG_CHR0:    chr0_q = shifted;
            slbm_pkg::REG_CHR1:    chr1_q = shifted;
            default:               prg_q  = shifted;
          endcase
          loads_seen[target]++;
          shift_q = '0;
          count_q = '0;
        end else begin
          shift_q = shifted;
          count_q = count_q + 1'b1;
        end
      end
    end

    // CHR: 8 KB mode keeps PPU A12 as the low line.
    if (!ctrl_q[4])
      res.chr_bank_lines = {chr0_q[4:1], it.ppu_addr_12};
    else
      res.chr_bank_lines = it.ppu_addr_12 ? chr1_q : chr0_q;

    case (slbm_pkg::prg_mode_t'(ctrl_q[3:2]))
      slbm_pkg::PRG_MODE_32K_A,
      slbm_pkg::PRG_MODE_32K_B:
        res.prg_bank_lines = {prg_q[3:1], it.cpu_addr_14};
      slbm_pkg::PRG_MODE_FIX_LO:
        res.prg_bank_lines = it.cpu_addr_14 ? prg_q[3:0] : 4'h0;
      default:
        res.prg_bank_lines = it.cpu_addr_14 ? 4'hf : prg_q[3:0];
    endcase

    case (slbm_pkg::mirror_t'(ctrl_q[1:0]))
      slbm_pkg::MIR_ONE_LO: res.nametable_a10 = 1'b0;
      slbm_pkg::MIR_ONE_HI: res.nametable_a10 = 1'b1;
      slbm_pkg::MIR_VERT:   res.nametable_a10 = it.ppu_addr_10;
      default:              res.nametable_a10 = it.ppu_addr_11;
    endcase

    res.sram_enable  = it.rom_select_n & it.cpu_addr_13 & it.cpu_addr_14 & it.phi_two;
    res.prg_enable_n = it.rom_select_n | ~it.cpu_read_n;
  endtask

  // Build one bus cycle; M2 and the PPU address bits are always random.
  function automatic slbm_pkg::in_item_t bus_cycle(input bit rd_n, input bit rs_n,
                                                   input bit a13, input bit a14,
                                                   input bit d0, input bit d7);
    slbm_pkg::in_item_t it;
    it.cpu_read_n     = rd_n;
    it.rom_select_n   = rs_n;
    it.cpu_addr_13    = a13;
    it.cpu_addr_14    = a14;
    it.data_bit_zero  = d0;
    it.data_bit_seven = d7;
    it.phi_two        = rand_bit();
    it.ppu_addr_10    = rand_bit();
    it.ppu_addr_11    = rand_bit();
    it.ppu_addr_12    = rand_bit();
    return it;
  endfunction

  task automatic queue_cycle(input slbm_pkg::in_item_t it);
    pending_cycles.push_back(it);
    n_queued++;
  endtask

  // Fully random cycle: any mix of read, write, ROM select and data bits.
  task automatic queue_noise();
    queue_cycle(bus_cycle(rand_bit(), rand_bit(), rand_bit(),
                          rand_bit(), rand_bit(), rand_bit()));
  endtask

  // A cycle that never touches the serial port: a read, or outside ROM space.
  task automatic queue_idle_bus();
    bit rd_n;
    bit rs_n;
    rd_n = rand_bit();
    rs_n = rd_n ? rand_bit() : 1'b1;
    queue_cycle(bus_cycle(rd_n, rs_n, rand_bit(), rand_bit(),
                          rand_bit(), rand_bit()));
  endtask

  // Five ROM writes, LSB first; only the fifth write's address picks the target.
  task automatic queue_serial_load(input slbm_pkg::reg_sel_t sel,
                                   input logic [slbm_pkg::BANK_W-1:0] value,
                                   input int gap_pct);
    for (int b = 0; b < slbm_pkg::BANK_W; b++) begin
      if (b == slbm_pkg::BANK_W - 1)
        queue_cycle(bus_cycle(1'b0, 1'b0, sel[0], sel[1], value[b], 1'b0));
      else
        queue_cycle(bus_cycle(1'b0, 1'b0, rand_bit(), rand_bit(),
                              value[b], 1'b0));
      if (b != slbm_pkg::BANK_W - 1 && $urandom_range(99) < gap_pct)
        queue_idle_bus();
    end
  endtask

  // Driver: present a new item on the falling edge once the last one is taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm_window() || ($urandom_range(99) >= IDLE_PCT);
      // Hold the current item until it has been accepted.
      if (!in_valid || n_accepted == n_offered) begin
        if (pending_cycles.size() == 0 ||
            (!calm_window() && $urandom_range(99) < IDLE_PCT)) begin
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data  <= pending_cycles.pop_front();
          n_offered++;
        end
      end
    end
  end

  // Monitor: check output items first, then predict from accepted inputs.
  // The output is registered, so an output never belongs to the
  // input accepted on the same edge.
  always @(posedge clk) begin
    slbm_pkg::out_item_t want;
    slbm_pkg::out_item_t predicted;
    cycle_no++;
    if (!rst_n) begin
      reset_mapper_model();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_lines.size() == 0) begin
          report_mismatch("unexpected output item", 32'(out_data), 0);
        end else begin
          want = expected_lines.pop_front();
          if (out_data.chr_bank_lines !== want.chr_bank_lines)
            report_mismatch("chr_bank_lines", 32'(out_data.chr_bank_lines),
                            32'(want.chr_bank_lines));
          if (out_data.prg_bank_lines !== want.prg_bank_lines)
            report_mismatch("prg_bank_lines", 32'(out_data.prg_bank_lines),
                            32'(want.prg_bank_lines));
          if (out_data.nametable_a10 !== want.nametable_a10)
            report_mismatch("nametable_a10", 32'(out_data.nametable_a10),
                            32'(want.nametable_a10));
          if (out_data.sram_enable !== want.sram_enable)
            report_mismatch("sram_enable", 32'(out_data.sram_enable),
                            32'(want.sram_enable));
          if (out_data.prg_enable_n !== want.prg_enable_n)
            report_mismatch("prg_enable_n", 32'(out_data.prg_enable_n),
                            32'(want.prg_enable_n));
          n_checked++;
        end
      end
      if (in_valid && in_ready) begin
        decode_bus_cycle(in_data, predicted);
        expected_lines.push_back(predicted);
        n_accepted++;
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int pick;
    int k;

    // Directed: reset-state decode, SRAM window, serial reset, extreme loads.
    queue_cycle(bus_cycle(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0));
    queue_cycle(bus_cycle(1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1));
    queue_cycle(bus_cycle(1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0));
    queue_cycle(bus_cycle(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1));
    queue_serial_load(slbm_pkg::REG_CHR0, 5'h1f, 0);
    queue_serial_load(slbm_pkg::REG_PRG, 5'h1f, 0);
    queue_serial_load(slbm_pkg::REG_CHR1, 5'h0a, 0);
    queue_serial_load(slbm_pkg::REG_CONTROL, 5'h1f, 0);
    // Abort a partial load with a D7 write.
    queue_cycle(bus_cycle(1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0));
    queue_cycle(bus_cycle(1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1));

    // Random: mostly complete loads, some aborted loads, some noise.
    while (n_queued < ITEM_TARGET) begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        queue_serial_load(slbm_pkg::reg_sel_t'(2'($urandom_range(3))),
                          5'($urandom_range(31)), 20);
      end else if (pick < 80) begin
        k = $urandom_range(1, 4);
        repeat (k)
          queue_cycle(bus_cycle(1'b0, 1'b0, rand_bit(), rand_bit(),
                                rand_bit(), 1'b0));
        queue_cycle(bus_cycle(1'b0, 1'b0, rand_bit(), rand_bit(),
                              rand_bit(), 1'b1));
      end else begin
        k = $urandom_range(1, 4);
        repeat (k) queue_noise();
      end
    end

    // Hold reset, then release it on a falling edge.
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_cycles.size() != 0 || in_valid) @(posedge clk);
    while (expected_lines.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_lines.size() != 0)
      report_mismatch("output items still owed", expected_lines.size(), 0);

    $display("Ran %0d bus cycles, checked %0d output items, %0d serial resets.",
             n_accepted, n_checked, n_bus_resets);
    $display("Register loads: control %0d, chr0 %0d, chr1 %0d, prg %0d.",
             loads_seen[slbm_pkg::REG_CONTROL], loads_seen[slbm_pkg::REG_CHR0],
             loads_seen[slbm_pkg::REG_CHR1], loads_seen[slbm_pkg::REG_PRG]);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("Timeout with %0d items pending.", pending_cycles.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
`default_nettype wire
